@@ design/hid_report_button_mapper_top_defines.svh @@
// assertion macros shared by the button mapper rtl
`ifndef HID_REPORT_BUTTON_MAPPER_TOP_DEFINES_SVH
`define HID_REPORT_BUTTON_MAPPER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold on every clock edge outside reset
`define HRBM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hrbm: assertion failed");

// consequent must hold in the cycle after the antecedent
`define HRBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrbm: assertion failed");

`else

`define HRBM_ASSERT(label, clk, rst, prop)
`define HRBM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/hrbm_pkg.sv @@
// shared types and constants of the joypad report button mapper
package hrbm_pkg;

   // rule layout: three 17-bit rules per configuration register
   localparam int RULE_COUNT    = 12;
   localparam int RULE_W        = 17;
   localparam int RULE_POS_W    = 6;
   localparam int RULES_PER_REG = 3;
   localparam int RULE_REGS     = 4;
   localparam int REG_W         = 51;

   // configuration port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_RULES_A  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RULES_B  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RULES_C  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RULES_D  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAINING = 3'd4;

   // training mode codes, code 3 behaves as detect
   localparam logic [1:0] TM_OFF    = 2'd0;
   localparam logic [1:0] TM_DETECT = 2'd1;
   localparam logic [1:0] TM_LEARN  = 2'd2;

   // rule test codes, codes 6 and 7 behave as none
   localparam logic [2:0] TEST_NONE  = 3'd0;
   localparam logic [2:0] TEST_GT    = 3'd1;
   localparam logic [2:0] TEST_LT    = 3'd2;
   localparam logic [2:0] TEST_CLEAR = 3'd3;
   localparam logic [2:0] TEST_SET   = 3'd4;
   localparam logic [2:0] TEST_EQ    = 3'd5;

   // result fields
   localparam int FIRST_W = 7;
   localparam logic [FIRST_W-1:0] NO_CHANGE = 7'd64;
   localparam logic [7:0] COUNT_MAX = 8'hFF;
   localparam logic [7:0] MASK_ALL  = 8'hFF;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   // button bits set by each rule: up, down, left, right, four diagonals, fires, start
   localparam logic [7:0] RULE_LUT [RULE_COUNT] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h09, 8'h0A, 8'h06, 8'h05,
      8'h10, 8'h20, 8'h40, 8'h80
   };

   typedef struct packed {
      logic [7:0]            value;
      logic [2:0]            test;
      logic [RULE_POS_W-1:0] pos;
   } rule_type;

   typedef struct packed {
      logic prev_we;
      logic mask_we;
      logic forget;
   } tmem_wr_type;

   typedef struct packed {
      logic [7:0]         buttons;
      logic [7:0]         change_count;
      logic [FIRST_W-1:0] first_change;
   } rsp_type;

endpackage

@@ design/hrbm_chan_if.sv @@
// valid/ready channel interfaces for report bytes and button results
interface hrbm_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] report_byte;
   logic       last_byte;

   modport source (output valid, output mode, output report_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input mode, input report_byte, input last_byte,
                   output ready);
endinterface

interface hrbm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] buttons;
   logic [7:0] change_count;
   logic [6:0] first_change;

   modport source (output valid, output buttons, output change_count, output first_change,
                   input ready);
   modport sink   (input valid, input buttons, input change_count, input first_change,
                   output ready);
endinterface

@@ design/hid_report_button_mapper_top.sv @@
// joypad report button mapper: rules, change tracking and result queue
//
//  channel   dir  transfer unit              payload
//  req_ch    in   one report byte or cmd     mode, report_byte, last_byte
//  rsp_ch    out  one result per report      buttons, change_count, first_change
//  csr_*     in   one register write         csr_index, csr_wdata
//
//  one byte is taken every cycle while req_ch is ready; a result is pushed into the
//  queue from the tracking stage, after the registered read of the training memories.
//  req_ch stalls only while the four-entry result queue plus the result in the
//  tracking stage would fill it.
//  synchronous reset; no clearing pass, the change mask uses a fill count.
//  a report byte rewritten at the same position on the next cycle is forwarded.
`include "hid_report_button_mapper_top_defines.svh"

module hid_report_button_mapper_top import hrbm_pkg::*; #(
   parameter int MAX_REPORT_BYTES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   hrbm_req_if.sink             req_ch,
   hrbm_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   localparam int POS_W  = $clog2(MAX_REPORT_BYTES + 1);
   localparam int ADDR_W = $clog2(MAX_REPORT_BYTES);

   // configuration
   logic [RULE_REGS-1:0][REG_W-1:0] rules_ff;
   logic [1:0]                      training_ff;
   logic                            forget;

   // first stage
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   logic               in_range;
   logic               acc;
   logic               byte_acc;
   logic               rd_en;
   logic [7:0]         rule_hits;

   // tracking stage
   logic               s2_valid_ff;
   logic               s2_mode_ff;
   logic               s2_last_ff;
   logic               s2_in_range_ff;
   logic [7:0]         s2_byte_ff;
   logic [POS_W-1:0]   s2_pos_ff;
   logic [7:0]         s2_hits_ff;
   logic               s2_result;

   // tracking state
   logic [7:0]         partial_ff;
   logic [7:0]         partial_in;
   logic               changed_ff;
   logic               changed_in;
   logic [7:0]         seen_ff;
   logic [7:0]         seen_in;
   logic [FIRST_W-1:0] first_ff;
   logic [FIRST_W-1:0] first_in;
   logic               mask_ready_ff;
   logic               mask_ready_in;

   // training memory path
   tmem_wr_type        tmem_wr;
   logic [7:0]         prev_q;
   logic [7:0]         mask_q;
   logic [7:0]         diff;
   logic [7:0]         mask_new;
   logic               training_on;
   logic               learn;
   logic               track;
   logic               byte_changed;

   // result path
   logic               push;
   rsp_type            push_data;
   logic [RSP_CNT_W-1:0] fifo_count;

   // configuration writes
   assign forget = csr_we && (csr_index == CSR_TRAINING) && (csr_wdata[1:0] == TM_OFF);

   always_ff @(posedge clock) begin
      if (reset) begin
         rules_ff    <= '0;
         training_ff <= TM_OFF;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RULES_A:  rules_ff[0] <= csr_wdata;
            CSR_RULES_B:  rules_ff[1] <= csr_wdata;
            CSR_RULES_C:  rules_ff[2] <= csr_wdata;
            CSR_RULES_D:  rules_ff[3] <= csr_wdata;
            CSR_TRAINING: training_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // input handshake: room for every result that can still arrive
   assign s2_result    = s2_valid_ff && !s2_mode_ff && s2_last_ff;
   assign req_ch.ready = (fifo_count + RSP_CNT_W'(s2_result)) < RSP_CNT_W'(RSP_DEPTH);
   assign acc          = req_ch.valid && req_ch.ready;
   assign byte_acc     = acc && !req_ch.mode;
   assign in_range     = pos_ff < POS_W'(MAX_REPORT_BYTES);
   assign rd_en        = byte_acc && in_range;

   // byte position, saturating past the last stored byte
   always_comb begin
      pos_in = pos_ff;
      if (byte_acc) begin
         if (req_ch.last_byte) begin
            pos_in = '0;
         end else if (in_range) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   hrbm_rules #(
      .POS_W (POS_W)
   ) u_rules (
      .rule_regs   (rules_ff),
      .pos         (pos_ff),
      .report_byte (req_ch.report_byte),
      .hits        (rule_hits)
   );

   // first stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         s2_valid_ff <= acc;
      end
   end

   always_ff @(posedge clock) begin
      s2_mode_ff     <= req_ch.mode;
      s2_last_ff     <= req_ch.last_byte;
      s2_in_range_ff <= in_range;
      s2_byte_ff     <= req_ch.report_byte;
      s2_pos_ff      <= pos_ff;
      s2_hits_ff     <= in_range ? rule_hits : 8'h00;
   end

   hrbm_tmem #(
      .DEPTH (MAX_REPORT_BYTES)
   ) u_tmem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (pos_ff[ADDR_W-1:0]),
      .wr      (tmem_wr),
      .wr_prev (s2_byte_ff),
      .wr_mask (mask_new),
      .prev_q  (prev_q),
      .mask_q  (mask_q)
   );

   // change detection against the previous report, mask learned first
   assign training_on  = training_ff != TM_OFF;
   assign learn        = training_ff == TM_LEARN;
   assign track        = s2_valid_ff && !s2_mode_ff && s2_in_range_ff && training_on;
   assign diff         = s2_byte_ff ^ prev_q;
   assign mask_new     = (learn && mask_ready_ff) ? (mask_q & ~diff) : mask_q;
   assign byte_changed = track && mask_ready_ff && ((diff & mask_new) != 8'h00);

   assign tmem_wr.prev_we = track;
   assign tmem_wr.mask_we = track && mask_ready_ff;
   assign tmem_wr.forget  = forget;

   // report-level tracking and result assembly
   always_comb begin
      logic [7:0]         bits_all;
      logic               changed_now;
      logic [FIRST_W-1:0] first_now;
      logic [7:0]         seen_now;

      bits_all      = partial_ff | s2_hits_ff;
      changed_now   = changed_ff || byte_changed;
      first_now     = first_ff;
      seen_now      = seen_ff;
      partial_in    = partial_ff;
      changed_in    = changed_ff;
      seen_in       = seen_ff;
      first_in      = first_ff;
      mask_ready_in = mask_ready_ff;
      push          = 1'b0;

      if (byte_changed && (first_ff == NO_CHANGE) && (32'(s2_pos_ff) < 32'(NO_CHANGE))) begin
         first_now = FIRST_W'(s2_pos_ff);
      end

      if (s2_valid_ff) begin
         if (s2_mode_ff) begin
            first_in   = NO_CHANGE;
            seen_in    = 8'h00;
            changed_in = 1'b0;
         end else if (s2_last_ff) begin
            if (training_on) begin
               if (mask_ready_ff) begin
                  if (changed_now && (seen_ff != COUNT_MAX)) begin
                     seen_now = seen_ff + 8'd1;
                  end
               end else begin
                  mask_ready_in = 1'b1;
               end
            end
            partial_in = 8'h00;
            changed_in = 1'b0;
            seen_in    = seen_now;
            first_in   = first_now;
            push       = 1'b1;
         end else begin
            partial_in = bits_all;
            changed_in = changed_now;
            first_in   = first_now;
         end
      end

      if (forget) begin
         mask_ready_in = 1'b0;
         changed_in    = 1'b0;
      end

      push_data.buttons      = bits_all;
      push_data.change_count = seen_now;
      push_data.first_change = first_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff    <= 8'h00;
         changed_ff    <= 1'b0;
         seen_ff       <= 8'h00;
         first_ff      <= '0;
         mask_ready_ff <= 1'b0;
      end else begin
         partial_ff    <= partial_in;
         changed_ff    <= changed_in;
         seen_ff       <= seen_in;
         first_ff      <= first_in;
         mask_ready_ff <= mask_ready_in;
      end
   end

   hrbm_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .count     (fifo_count),
      .rsp_ch    (rsp_ch)
   );

   // a result leaving the tracking stage always finds queue room
   `HRBM_ASSERT(a_rsp_room, clock, reset, s2_result |-> (fifo_count < RSP_CNT_W'(RSP_DEPTH)))

   // the last byte of a report restarts the position
   `HRBM_ASSERT_NEXT(a_pos_wrap, clock, reset, byte_acc && req_ch.last_byte, pos_ff == '0)

   // a detection reset clears the count and the first change
   `HRBM_ASSERT_NEXT(a_det_reset, clock, reset, s2_valid_ff && s2_mode_ff,
                     (seen_ff == 8'h00) && (first_ff == NO_CHANGE))

endmodule

@@ design/hrbm_rules.sv @@
// twelve parallel rule matchers for one report byte
module hrbm_rules import hrbm_pkg::*; #(
   parameter int POS_W = 7
) (
   input  logic [RULE_REGS-1:0][REG_W-1:0] rule_regs,
   input  logic [POS_W-1:0]                pos,
   input  logic [7:0]                      report_byte,
   output logic [7:0]                      hits
);

   localparam int CMP_W = (POS_W > RULE_POS_W) ? POS_W : RULE_POS_W;

   logic [RULE_COUNT-1:0] rule_hit;

   // one matcher per rule
   for (genvar k = 0; k < RULE_COUNT; k++) begin : g_rule
      localparam int RegIdx = k / RULES_PER_REG;
      localparam int Lsb    = (k % RULES_PER_REG) * RULE_W;

      rule_type rule;
      logic     pos_match;
      logic     test_hit;

      assign rule      = rule_type'(rule_regs[RegIdx][Lsb +: RULE_W]);
      assign pos_match = CMP_W'(rule.pos) == CMP_W'(pos);

      always_comb begin
         unique case (rule.test)
            TEST_GT:    test_hit = report_byte > rule.value;
            TEST_LT:    test_hit = report_byte < rule.value;
            TEST_CLEAR: test_hit = (report_byte & rule.value) == 8'h00;
            TEST_SET:   test_hit = (report_byte & rule.value) != 8'h00;
            TEST_EQ:    test_hit = report_byte == rule.value;
            default:    test_hit = 1'b0;
         endcase
      end

      assign rule_hit[k] = pos_match && test_hit;
   end

   // merge matched rules into button bits
   always_comb begin
      hits = 8'h00;
      for (int k = 0; k < RULE_COUNT; k++) begin
         if (rule_hit[k]) begin
            hits = hits | RULE_LUT[k];
         end
      end
   end

endmodule

@@ design/hrbm_tmem.sv @@
// previous-report and change-mask memories with write forwarding
module hrbm_tmem import hrbm_pkg::*; #(
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int FILL_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  tmem_wr_type       wr,
   input  logic [7:0]        wr_prev,
   input  logic [7:0]        wr_mask,
   output logic [7:0]        prev_q,
   output logic [7:0]        mask_q
);

   logic [7:0]        prev_mem_ff [DEPTH];
   logic [7:0]        mask_mem_ff [DEPTH];
   logic [7:0]        prev_rd_ff;
   logic [7:0]        mask_rd_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [7:0]        fwd_prev_ff;
   logic [7:0]        fwd_mask_ff;
   logic              fwd_prev_hit_ff;
   logic              fwd_prev_hit_in;
   logic              fwd_mask_hit_ff;
   logic              fwd_mask_hit_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [FILL_W-1:0] wr_end;
   logic              mask_valid;

   // read port in the first stage, write-back at the registered address
   always_ff @(posedge clock) begin
      if (rd_en) begin
         prev_rd_ff <= prev_mem_ff[rd_addr];
         mask_rd_ff <= mask_mem_ff[rd_addr];
      end
      if (wr.prev_we) begin
         prev_mem_ff[addr_ff] <= wr_prev;
      end
      if (wr.mask_we) begin
         mask_mem_ff[addr_ff] <= wr_mask;
      end
      addr_ff     <= rd_addr;
      fwd_prev_ff <= wr_prev;
      fwd_mask_ff <= wr_mask;
   end

   // mask entries are written as a prefix from position zero, so a fill count
   // stands in for the all-ones reset
   assign wr_end          = FILL_W'(addr_ff) + FILL_W'(1);
   assign fwd_prev_hit_in = rd_en && wr.prev_we && (rd_addr == addr_ff);
   assign fwd_mask_hit_in = rd_en && wr.mask_we && (rd_addr == addr_ff);

   always_comb begin
      fill_in = fill_ff;
      if (wr.forget) begin
         fill_in = '0;
      end else if (wr.mask_we && (wr_end > fill_ff)) begin
         fill_in = wr_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff         <= '0;
         fwd_prev_hit_ff <= 1'b0;
         fwd_mask_hit_ff <= 1'b0;
      end else begin
         fill_ff         <= fill_in;
         fwd_prev_hit_ff <= fwd_prev_hit_in;
         fwd_mask_hit_ff <= fwd_mask_hit_in;
      end
   end

   // read data with forwarding of a same-entry write-back
   assign mask_valid = FILL_W'(addr_ff) < fill_ff;
   assign prev_q     = fwd_prev_hit_ff ? fwd_prev_ff : prev_rd_ff;

   always_comb begin
      if (fwd_mask_hit_ff) begin
         mask_q = fwd_mask_ff;
      end else if (mask_valid) begin
         mask_q = mask_rd_ff;
      end else begin
         mask_q = MASK_ALL;
      end
   end

endmodule

@@ design/hrbm_rsp_fifo.sv @@
// small result queue between the tracking stage and the result channel
module hrbm_rsp_fifo import hrbm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsp_type              push_data,
   output logic [RSP_CNT_W-1:0] count,
   hrbm_rsp_if.source           rsp_ch
);

   rsp_type                entry_ff [RSP_DEPTH];
   rsp_type                head;
   logic [RSP_PTR_W-1:0]   wr_ptr_ff;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff;
   logic [RSP_CNT_W-1:0]   count_ff;
   logic [RSP_CNT_W-1:0]   count_in;
   logic                   pop;

   assign pop = rsp_ch.valid && rsp_ch.ready;

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill level
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + RSP_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // head of queue drives the channel
   assign head                = entry_ff[rd_ptr_ff];
   assign count               = count_ff;
   assign rsp_ch.valid        = count_ff != '0;
   assign rsp_ch.buttons      = head.buttons;
   assign rsp_ch.change_count = head.change_count;
   assign rsp_ch.first_change = head.first_change;

endmodule
